[rtl/core/invertible_bloom_table_update_lookup_macros.svh]
// Assertion macros for the lookup table block
`ifndef INVERTIBLE_BLOOM_TABLE_UPDATE_LOOKUP_MACROS_SVH
`define INVERTIBLE_BLOOM_TABLE_UPDATE_LOOKUP_MACROS_SVH

// ante implies cons in the same cycle
`define IBLT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iblt check failed");

// ante implies cons in the next cycle
`define IBLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iblt check failed");

`endif

[rtl/core/iblt_pkg.sv]
// Shared types and constants of the lookup table block
package iblt_pkg;

    localparam int TABLE_CELLS_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 64;
    localparam int MAX_HASHES_DEF  = 8;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [3:0]  HC_RESET   = 4'd3;
    localparam logic [10:0] BPH_RESET  = 11'd256;
    localparam logic [3:0]  CHECK_SEED = 4'd11;

    localparam logic        REG_HASH_COUNT = 1'b0;
    localparam logic        REG_BUCKETS    = 1'b1;

    localparam logic [1:0]  OP_INSERT = 2'd0;

    localparam logic [2:0]  ST_UPDATED = 3'd0;
    localparam logic [2:0]  ST_FOUND   = 3'd1;
    localparam logic [2:0]  ST_ABSENT  = 3'd2;
    localparam logic [2:0]  ST_UNKNOWN = 3'd3;
    localparam logic [2:0]  ST_BADCFG  = 3'd4;

    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_C3 = 32'h85ebca6b;
    localparam logic [31:0] MM_C4 = 32'hc2b2ae35;
    localparam logic [31:0] MM_M5 = 32'd5;
    localparam logic [31:0] MM_E  = 32'he6546b64;
    localparam logic [31:0] MM_LEN = 32'd8;

    typedef struct packed {
        logic        bad;
        logic        lookup;
        logic        insert;
        logic        last;
        logic [63:0] key;
        logic [31:0] check;
    } t_entry;

endpackage

[rtl/core/invertible_bloom_table_update_lookup.sv]
// Top level of the invertible Bloom lookup table with insert, erase and lookup
//
//  channel   signals                                   handshake
//  command   start, i_opcode, i_key, i_value_in        start && !busy
//  result    o_strobe, o_status, o_value_out           o_strobe, one cycle
//  config    i_cfg_we, i_cfg_index, i_cfg_wdata        i_cfg_we
//
// In the front one shared eight-step hash unit computes the check hash and then
// one key hash per region; a remainder step reduces each one bit per cycle.
// The back serves one region at a time; lookups check-hash a single-entry cell.
// After reset the store is cleared cell by cell with busy high.
// The result side cannot stall; the queue lets the front run ahead of the back.
`include "invertible_bloom_table_update_lookup_macros.svh"

module invertible_bloom_table_update_lookup #(
    parameter int TABLE_CELLS = iblt_pkg::TABLE_CELLS_DEF,
    parameter int VALUE_BITS  = iblt_pkg::VALUE_BITS_DEF,
    parameter int MAX_HASHES  = iblt_pkg::MAX_HASHES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value_in,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [63:0] o_value_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_wdata
);
    localparam int CW = $clog2(TABLE_CELLS);
    localparam int QW = $bits(iblt_pkg::t_entry) + CW + VALUE_BITS;

    logic [3:0]            r_hash_count;
    logic [10:0]           r_buckets;
    logic                  accept, f_idle, clearing;
    logic                  q_push, q_pop, q_empty, q_full;
    iblt_pkg::t_entry      f_entry, b_entry;
    logic [CW-1:0]         f_cell, b_cell;
    logic [VALUE_BITS-1:0] f_value, b_value;
    logic [QW-1:0]         q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count <= iblt_pkg::HC_RESET;
            r_buckets    <= iblt_pkg::BPH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iblt_pkg::REG_HASH_COUNT: r_hash_count <= i_cfg_wdata[3:0];
                default:                  r_buckets    <= i_cfg_wdata;
            endcase
        end
    end

    assign busy   = !f_idle || clearing;
    assign accept = start && !busy;

    iblt_front #(
        .TABLE_CELLS (TABLE_CELLS),
        .VALUE_BITS  (VALUE_BITS),
        .MAX_HASHES  (MAX_HASHES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_key        (i_key),
        .i_value      (i_value_in[VALUE_BITS-1:0]),
        .i_hash_count (r_hash_count),
        .i_buckets    (r_buckets),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_entry      (f_entry),
        .o_cell       (f_cell),
        .o_value      (f_value),
        .o_idle       (f_idle)
    );

    iblt_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_entry, f_cell, f_value}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_entry, b_cell, b_value} = q_out;

    iblt_back #(
        .TABLE_CELLS (TABLE_CELLS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_entry     (b_entry),
        .i_cell      (b_cell),
        .i_value     (b_value),
        .o_pop       (q_pop),
        .o_clearing  (clearing),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

    `IBLT_ASSERT_SAME(a_no_overflow, q_push, !q_full)
    `IBLT_ASSERT_NEXT(a_busy_after_accept, accept, busy)
    `IBLT_ASSERT_SAME(a_value_zero, o_strobe && (o_status != iblt_pkg::ST_FOUND), o_value_out == '0)
endmodule

[rtl/core/iblt_ram.sv]
// Generic single-port-write, registered-read RAM
module iblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/iblt_hash.sv]
// Eight-step MurmurHash3 x86_32 unit for one 64-bit key
module iblt_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [3:0]  i_seed,
    input  logic [63:0] i_key,
    output logic        o_done,
    output logic [31:0] o_hash
);
    logic        r_busy, r_done;
    logic [2:0]  r_step;
    logic [63:0] r_key;
    logic [31:0] r_h, r_k;
    logic [31:0] a, b, prod, t, n_h, n_k;

    function automatic logic [31:0] t_rot(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

    function automatic logic [31:0] MM_LEN_x();
        return iblt_pkg::MM_LEN;
    endfunction

    always_comb begin
        t   = r_h ^ MM_LEN_x();
        a   = '0;
        b   = '0;
        n_h = r_h;
        n_k = r_k;
        case (r_step)
            3'd0: begin a = r_key[31:0]; b = iblt_pkg::MM_C1; end
            3'd1: begin a = {r_k[16:0], r_k[31:17]}; b = iblt_pkg::MM_C2; end
            3'd2: begin a = {t_rot(r_h ^ r_k)}; b = iblt_pkg::MM_M5; end
            3'd3: begin a = r_key[63:32]; b = iblt_pkg::MM_C1; end
            3'd4: begin a = {r_k[16:0], r_k[31:17]}; b = iblt_pkg::MM_C2; end
            3'd5: begin a = {t_rot(r_h ^ r_k)}; b = iblt_pkg::MM_M5; end
            3'd6: begin a = t ^ (t >> 16); b = iblt_pkg::MM_C3; end
            default: begin a = r_h ^ (r_h >> 13); b = iblt_pkg::MM_C4; end
        endcase
        prod = a * b;
        case (r_step)
            3'd0, 3'd1, 3'd3, 3'd4: n_k = prod;
            3'd2, 3'd5: n_h = prod + iblt_pkg::MM_E;
            default: n_h = prod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_h   <= 32'(i_seed);
            r_k   <= '0;
        end else if (r_busy) begin
            r_h <= n_h;
            r_k <= n_k;
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h ^ (r_h >> 16);
endmodule

[rtl/core/iblt_queue.sv]
// Short flip-flop queue between front and back
module iblt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int QAW = $clog2(iblt_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [iblt_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QAW+1)'(iblt_pkg::QUEUE_DEPTH));
endmodule

[rtl/core/iblt_front.sv]
// Front: accept items, check configuration, compute cell indexes
module iblt_front #(
    parameter int TABLE_CELLS = iblt_pkg::TABLE_CELLS_DEF,
    parameter int VALUE_BITS  = iblt_pkg::VALUE_BITS_DEF,
    parameter int MAX_HASHES  = iblt_pkg::MAX_HASHES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_opcode,
    input  logic [63:0]                    i_key,
    input  logic [VALUE_BITS-1:0]          i_value,
    input  logic [3:0]                     i_hash_count,
    input  logic [10:0]                    i_buckets,
    input  logic                           i_full,
    output logic                           o_push,
    output iblt_pkg::t_entry               o_entry,
    output logic [$clog2(TABLE_CELLS)-1:0] o_cell,
    output logic [VALUE_BITS-1:0]          o_value,
    output logic                           o_idle
);
    localparam int CW = $clog2(TABLE_CELLS);
    localparam int IW = (CW + 1 > 12) ? CW + 1 : 12;

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_START = 5'b00010,
        F_HASH  = 5'b00100,
        F_MOD   = 5'b01000,
        F_PUSH  = 5'b10000
    } t_fstate;

    t_fstate               r_state;
    logic                  r_bad, r_lookup, r_insert, r_chk_phase;
    logic [63:0]           r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [31:0]           r_chk, r_div;
    logic [10:0]           r_rem;
    logic [4:0]            r_bit;
    logic [3:0]            r_region;
    logic [CW:0]           r_base;
    logic                  h_start, h_done, bad, last;
    logic [31:0]           h_val;
    logic [14:0]           cells;
    logic [11:0]           div_t;
    logic [IW-1:0]         idx;

    assign cells = 15'(i_hash_count) * 15'(i_buckets);
    assign bad   = (i_hash_count < 4'd2) || (32'(i_hash_count) > 32'(MAX_HASHES)) ||
                   (i_buckets == '0) || (32'(cells) > 32'(TABLE_CELLS));
    assign div_t = {r_rem, r_div[31]};
    assign last  = r_bad || (r_region == (i_hash_count - 4'd1));
    assign idx   = IW'(r_base) + IW'(r_rem);
    assign h_start = (r_state == F_START);

    iblt_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_seed  (r_chk_phase ? iblt_pkg::CHECK_SEED : r_region),
        .i_key   (r_key),
        .o_done  (h_done),
        .o_hash  (h_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE:  if (i_accept) r_state <= bad ? F_PUSH : F_START;
                F_START: r_state <= F_HASH;
                F_HASH:  if (h_done) r_state <= r_chk_phase ? F_START : F_MOD;
                F_MOD:   if (r_bit == 5'd31) r_state <= F_PUSH;
                F_PUSH:  if (!i_full) r_state <= last ? F_IDLE : F_START;
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_bad       <= bad;
                r_lookup    <= i_opcode[1];
                r_insert    <= (i_opcode == iblt_pkg::OP_INSERT);
                r_key       <= i_key;
                r_val       <= i_value;
                r_chk_phase <= 1'b1;
                r_region    <= '0;
                r_base      <= '0;
                r_rem       <= '0;
            end
            F_HASH: begin
                if (h_done) begin
                    if (r_chk_phase) begin
                        r_chk       <= h_val;
                        r_chk_phase <= 1'b0;
                    end else begin
                        r_div <= h_val;
                        r_rem <= '0;
                        r_bit <= '0;
                    end
                end
            end
            F_MOD: begin
                r_rem <= (div_t >= {1'b0, i_buckets}) ? 11'(div_t - {1'b0, i_buckets})
                                                       : div_t[10:0];
                r_div <= {r_div[30:0], 1'b0};
                r_bit <= r_bit + 5'd1;
            end
            F_PUSH: begin
                if (!i_full && !last) begin
                    r_region <= r_region + 4'd1;
                    r_base   <= r_base + (CW+1)'(i_buckets);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push         = (r_state == F_PUSH) && !i_full;
    assign o_entry.bad    = r_bad;
    assign o_entry.lookup = r_lookup;
    assign o_entry.insert = r_insert;
    assign o_entry.last   = last;
    assign o_entry.key    = r_key;
    assign o_entry.check  = r_chk;
    assign o_cell         = r_bad ? '0 : idx[CW-1:0];
    assign o_value        = r_val;
    assign o_idle         = (r_state == F_IDLE);
endmodule

[rtl/core/iblt_back.sv]
// Back: clear the store, run cell updates and lookups, drive results
module iblt_back #(
    parameter int TABLE_CELLS = iblt_pkg::TABLE_CELLS_DEF,
    parameter int VALUE_BITS  = iblt_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  iblt_pkg::t_entry               i_entry,
    input  logic [$clog2(TABLE_CELLS)-1:0] i_cell,
    input  logic [VALUE_BITS-1:0]          i_value,
    output logic                           o_pop,
    output logic                           o_clearing,
    output logic                           o_strobe,
    output logic [2:0]                     o_status,
    output logic [63:0]                    o_value_out
);
    localparam int CW = $clog2(TABLE_CELLS);
    localparam int RW = 112 + VALUE_BITS;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_EXEC  = 4'b0100,
        B_CHECK = 4'b1000
    } t_bstate;

    t_bstate               r_state;
    iblt_pkg::t_entry      r_ent;
    logic [CW-1:0]         r_cell, r_clr;
    logic [VALUE_BITS-1:0] r_val, r_vs;
    logic [63:0]           r_ks;
    logic [31:0]           r_cs;
    logic                  r_drop, r_strobe;
    logic [2:0]            r_status;
    logic [63:0]           r_value_out;

    logic                  we, re, h_start, h_done;
    logic [CW-1:0]         waddr;
    logic [RW-1:0]         wdata, q;
    logic [31:0]           h_val;
    logic [15:0]           cnt, ncnt;
    logic [63:0]           ks, nks;
    logic [31:0]           cs, ncs;
    logic [VALUE_BITS-1:0] vs, nvs;
    logic                  c_empty, n_empty, c_single;

    assign vs  = q[VALUE_BITS-1:0];
    assign cs  = q[VALUE_BITS+31:VALUE_BITS];
    assign ks  = q[VALUE_BITS+95:VALUE_BITS+32];
    assign cnt = q[VALUE_BITS+111:VALUE_BITS+96];

    assign ncnt    = r_ent.insert ? cnt + 16'd1 : cnt + 16'hffff;
    assign nks     = ks ^ r_ent.key;
    assign ncs     = cs ^ r_ent.check;
    assign n_empty = (ncnt == '0) && (nks == '0) && (ncs == '0);
    assign nvs     = n_empty ? '0 : vs ^ r_val;
    assign c_empty = (cnt == '0) && (ks == '0) && (cs == '0);
    assign c_single = (cnt == 16'd1) || (cnt == 16'hffff);

    assign re      = (r_state == B_IDLE) && !i_empty && !r_drop && !i_entry.bad;
    assign we      = (r_state == B_CLEAR) || ((r_state == B_EXEC) && !r_ent.lookup);
    assign waddr   = (r_state == B_CLEAR) ? r_clr : r_cell;
    assign wdata   = (r_state == B_CLEAR) ? '0 : {ncnt, nks, ncs, nvs};
    assign h_start = (r_state == B_EXEC) && r_ent.lookup && !c_empty && c_single;
    assign o_pop   = (r_state == B_IDLE) && !i_empty;

    iblt_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (i_cell),
        .o_rdata (q)
    );

    iblt_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_seed  (iblt_pkg::CHECK_SEED),
        .i_key   (ks),
        .o_done  (h_done),
        .o_hash  (h_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CW'(TABLE_CELLS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        if (r_drop) begin
                            if (i_entry.last) r_drop <= 1'b0;
                        end else if (i_entry.bad) begin
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= B_EXEC;
                        end
                    end
                end
                B_EXEC: begin
                    if (!r_ent.lookup) begin
                        r_strobe <= r_ent.last;
                        r_state  <= B_IDLE;
                    end else if (c_empty) begin
                        r_strobe <= 1'b1;
                        r_drop   <= !r_ent.last;
                        r_state  <= B_IDLE;
                    end else if (c_single) begin
                        r_state <= B_CHECK;
                    end else begin
                        r_strobe <= r_ent.last;
                        r_state  <= B_IDLE;
                    end
                end
                B_CHECK: begin
                    if (h_done) begin
                        if (h_val == r_cs) begin
                            r_strobe <= 1'b1;
                            r_drop   <= !r_ent.last;
                        end else begin
                            r_strobe <= r_ent.last;
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_ent       <= i_entry;
                r_cell      <= i_cell;
                r_val       <= i_value;
                r_status    <= iblt_pkg::ST_BADCFG;
                r_value_out <= '0;
            end
            B_EXEC: begin
                r_ks        <= ks;
                r_cs        <= cs;
                r_vs        <= vs;
                r_value_out <= '0;
                if (!r_ent.lookup) begin
                    r_status <= iblt_pkg::ST_UPDATED;
                end else if (c_empty) begin
                    r_status <= iblt_pkg::ST_ABSENT;
                end else begin
                    r_status <= iblt_pkg::ST_UNKNOWN;
                end
            end
            B_CHECK: begin
                if (h_done && (h_val == r_cs)) begin
                    if (r_ks == r_ent.key) begin
                        r_status    <= iblt_pkg::ST_FOUND;
                        r_value_out <= 64'(r_vs);
                    end else begin
                        r_status <= iblt_pkg::ST_ABSENT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_clearing  = (r_state == B_CLEAR);
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
endmodule

[sim/tb_top.sv]
// Self-checking testbench for the invertible Bloom lookup table block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_LOOKUP_ALT = 2'd3;
    localparam int NCELLS = iblt_pkg::TABLE_CELLS_DEF;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [63:0] i_key;
    logic [63:0] i_value_in;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [63:0] o_value_out;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [10:0] i_cfg_wdata;

    logic [15:0] tbl_count [NCELLS];
    logic [63:0] tbl_key   [NCELLS];
    logic [31:0] tbl_check [NCELLS];
    logic [63:0] tbl_value [NCELLS];
    logic [3:0]  regions;
    logic [10:0] buckets;

    t_answer     pending_answers[$];
    logic [63:0] live_keys[$];
    int          errors;
    longint      cycles;

    invertible_bloom_table_update_lookup i_dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] murmur_round(logic [31:0] h, logic [31:0] k);
        k = k * iblt_pkg::MM_C1;
        k = {k[16:0], k[31:17]};
        k = k * iblt_pkg::MM_C2;
        h = h ^ k;
        h = {h[18:0], h[31:19]};
        return h * iblt_pkg::MM_M5 + iblt_pkg::MM_E;
    endfunction

    function automatic logic [31:0] murmur64(logic [31:0] seed, logic [63:0] key);
        logic [31:0] h;
        h = murmur_round(seed, key[31:0]);
        h = murmur_round(h, key[63:32]);
        h = h ^ iblt_pkg::MM_LEN;
        h = h ^ (h >> 16);
        h = h * iblt_pkg::MM_C3;
        h = h ^ (h >> 13);
        h = h * iblt_pkg::MM_C4;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int cell_of(int r, logic [63:0] key);
        logic [31:0] h;
        h = murmur64(r, key);
        return r * buckets + int'(h % {21'd0, buckets});
    endfunction

    function automatic bit is_empty(int c);
        return tbl_count[c] == 0 && tbl_key[c] == 0 && tbl_check[c] == 0;
    endfunction

    function automatic t_answer apply_item(logic [1:0] op, logic [63:0] key,
                                           logic [63:0] val);
        t_answer     a;
        int          c;
        logic [31:0] chk;
        a.status = iblt_pkg::ST_UPDATED;
        a.value  = '0;
        if (regions < 2 || regions > iblt_pkg::MAX_HASHES_DEF || buckets == 0 ||
            int'(regions) * int'(buckets) > NCELLS) begin
            a.status = iblt_pkg::ST_BADCFG;
            return a;
        end
        if (!op[1]) begin
            chk = murmur64(32'(iblt_pkg::CHECK_SEED), key);
            for (int r = 0; r < regions; r++) begin
                c = cell_of(r, key);
                tbl_count[c] = (op == iblt_pkg::OP_INSERT) ? tbl_count[c] + 16'd1
                                                           : tbl_count[c] - 16'd1;
                tbl_key[c]   ^= key;
                tbl_check[c] ^= chk;
                if (is_empty(c))
                    tbl_value[c] = '0;
                else
                    tbl_value[c] ^= val;
            end
            return a;
        end
        a.status = iblt_pkg::ST_UNKNOWN;
        for (int r = 0; r < regions; r++) begin
            c = cell_of(r, key);
            if (is_empty(c)) begin
                a.status = iblt_pkg::ST_ABSENT;
                return a;
            end
            if ((tbl_count[c] == 16'h0001 || tbl_count[c] == 16'hffff) &&
                tbl_check[c] == murmur64(32'(iblt_pkg::CHECK_SEED), tbl_key[c])) begin
                if (tbl_key[c] == key) begin
                    a.status = iblt_pkg::ST_FOUND;
                    a.value  = tbl_value[c];
                end else begin
                    a.status = iblt_pkg::ST_ABSENT;
                end
                return a;
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result status %0d value %h",
                         $time, o_status, o_value_out);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_value_out !== want.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, o_value_out);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [63:0] key, logic [63:0] val);
        start      <= 1'b1;
        i_opcode   <= op;
        i_key      <= key;
        i_value_in <= val;
        do @(posedge i_clk); while (busy);
        pending_answers.push_back(apply_item(op, key, val));
        if (op == iblt_pkg::OP_INSERT)
            live_keys.push_back(key);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0 || busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == iblt_pkg::REG_HASH_COUNT)
            regions = data[3:0];
        else
            buckets = data;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_burst(int n);
        int          left;
        int          pick;
        logic [1:0]  op;
        logic [63:0] key;
        left = n;
        while (left > 0) begin
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
                pick = $urandom_range(0, 99);
                op = pick < 40 ? iblt_pkg::OP_INSERT : pick < 60 ? OP_ERASE :
                     pick < 95 ? OP_LOOKUP : OP_LOOKUP_ALT;
                if (live_keys.size() != 0 && $urandom_range(0, 9) < 6) begin
                    pick = $urandom_range(0, live_keys.size() - 1);
                    key = live_keys[pick];
                    if (op == OP_ERASE)
                        live_keys.delete(pick);
                end else begin
                    key = rand64();
                end
                send_item(op, key, rand64());
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(0, $urandom_range(0, 1) ? 4 : 25));
        end
    endtask

    task automatic test_directed();
        send_item(OP_LOOKUP, '0, '0);
        send_item(iblt_pkg::OP_INSERT, '0, '0);
        send_item(iblt_pkg::OP_INSERT, '1, '1);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_LOOKUP_ALT, '0, '1);
        send_item(OP_ERASE, 64'h0123_4567_89ab_cdef, 64'hfeed_5555_aaaa_0001);
        send_item(OP_LOOKUP, 64'h0123_4567_89ab_cdef, '0);
        send_item(OP_ERASE, '1, '1);
        send_item(OP_LOOKUP, '1, '0);
        send_item(iblt_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);
        send_item(OP_LOOKUP, 64'h8000_0000_0000_0001, '0);
        send_item(OP_LOOKUP, 64'h5a5a_5a5a_5a5a_5a5a, '0);
        write_reg(iblt_pkg::REG_BUCKETS, 11'd1);
        write_reg(iblt_pkg::REG_HASH_COUNT, 11'd2);
        send_item(iblt_pkg::OP_INSERT, 64'hdead_beef, 64'h1234);
        send_item(OP_LOOKUP, 64'hdead_beef, '0);
        send_item(OP_LOOKUP, 64'h7, '0);
        send_item(iblt_pkg::OP_INSERT, 64'h77, 64'h99);
        send_item(OP_LOOKUP, 64'h77, '0);
        drain();
    endtask

    task automatic test_bad_config();
        logic [10:0] bad_hc [4] = '{11'd0, 11'd1, 11'd9, 11'h7ff};
        foreach (bad_hc[i]) begin
            write_reg(iblt_pkg::REG_HASH_COUNT, bad_hc[i]);
            random_burst(3);
        end
        write_reg(iblt_pkg::REG_HASH_COUNT, 11'd2);
        write_reg(iblt_pkg::REG_BUCKETS, 11'd0);
        random_burst(3);
        write_reg(iblt_pkg::REG_BUCKETS, 11'd1024);
        random_burst(3);
        write_reg(iblt_pkg::REG_BUCKETS, 11'd513);
        random_burst(3);
        write_reg(iblt_pkg::REG_BUCKETS, 11'd512);
        random_burst(40);
        write_reg(iblt_pkg::REG_HASH_COUNT, 11'd8);
        random_burst(3);
    endtask

    task automatic test_random(int hc, int bph, int n);
        write_reg(iblt_pkg::REG_HASH_COUNT, {7'($urandom_range(0, 127)), hc[3:0]});
        write_reg(iblt_pkg::REG_BUCKETS, bph[10:0]);
        live_keys.delete();
        random_burst(n);
    endtask

    initial begin
        errors      = 0;
        cycles      = 0;
        regions     = iblt_pkg::HC_RESET;
        buckets     = iblt_pkg::BPH_RESET;
        for (int c = 0; c < NCELLS; c++) begin
            tbl_count[c] = '0;
            tbl_key[c]   = '0;
            tbl_check[c] = '0;
            tbl_value[c] = '0;
        end
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_opcode    = '0;
        i_key       = '0;
        i_value_in  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_wdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_bad_config();
        test_random(8, 128, 150);
        test_random(2, 4, 300);
        test_random(3, 16, 400);
        test_random(2, 512, 250);
        test_random(4, 2, 250);
        test_random(5, 200, 300);
        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
